FILE: rtl/pswa_pkg.sv
package pswa_pkg;

    // Window size and derived widths
    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_W     = 32;
    localparam int SAMPLES_W    = 7;
    localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int STEP_W       = $clog2(SUM_W);

    // Job queue between front and back (depth is a power of two)
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // One input item
    typedef struct packed {
        logic [SAMPLE_W-1:0] queue_wait_sample;
        logic [SAMPLE_W-1:0] inference_sample;
    } t_in;

    // One result item
    typedef struct packed {
        logic [SAMPLE_W-1:0]  avg_queue_wait;
        logic [SAMPLE_W-1:0]  avg_inference;
        logic [SAMPLES_W-1:0] samples_held;
    } t_out;

    // Division job handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0]   wait_sum;
        logic [SUM_W-1:0]   latency_sum;
        logic [COUNT_W-1:0] count;
    } t_job;

endpackage

FILE: rtl/pswa_front.sv
module pswa_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  pswa_pkg::t_in  i_item,
    output logic           o_job_push,
    input  logic           i_job_full,
    output pswa_pkg::t_job o_job
);
    import pswa_pkg::*;

    typedef enum logic [3:0] {
        FS_IDLE = 4'b0001,
        FS_SUB  = 4'b0010,
        FS_ADD  = 4'b0100,
        FS_PUSH = 4'b1000
    } t_front_state;

    t_front_state r_state, n_state;
    logic [SUM_W-1:0]    r_wait_sum, n_wait_sum;
    logic [SUM_W-1:0]    r_lat_sum, n_lat_sum;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    t_in                 r_item;
    logic [SAMPLE_W-1:0] r_rd_wait, r_rd_lat;
    logic [SAMPLE_W-1:0] r_wait_ring [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_lat_ring [WINDOW_DEPTH];
    logic                accept;
    logic                ring_full;
    logic                ring_we;

    assign o_full    = (r_state != FS_IDLE);
    assign accept    = i_push && !o_full;
    assign ring_full = (r_count == COUNT_W'(WINDOW_DEPTH));
    assign ring_we   = (r_state == FS_ADD);

    assign o_job_push        = (r_state == FS_PUSH);
    assign o_job.wait_sum    = r_wait_sum;
    assign o_job.latency_sum = r_lat_sum;
    assign o_job.count       = r_count;

    // Drop the oldest pair once the window is full, then add the new pair
    always_comb begin
        n_state    = r_state;
        n_wait_sum = r_wait_sum;
        n_lat_sum  = r_lat_sum;
        n_count    = r_count;
        n_slot     = r_slot;
        unique case (r_state)
            FS_IDLE: begin
                if (accept) begin
                    n_state = FS_SUB;
                end
            end
            FS_SUB: begin
                if (ring_full) begin
                    n_wait_sum = r_wait_sum - SUM_W'(r_rd_wait);
                    n_lat_sum  = r_lat_sum - SUM_W'(r_rd_lat);
                end else begin
                    n_count = r_count + COUNT_W'(1);
                end
                n_state = FS_ADD;
            end
            FS_ADD: begin
                n_wait_sum = r_wait_sum + SUM_W'(r_item.queue_wait_sample);
                n_lat_sum  = r_lat_sum + SUM_W'(r_item.inference_sample);
                if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                    n_slot = '0;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_job_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    // Control and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_IDLE;
            r_wait_sum <= '0;
            r_lat_sum  <= '0;
            r_count    <= '0;
            r_slot     <= '0;
        end else begin
            r_state    <= n_state;
            r_wait_sum <= n_wait_sum;
            r_lat_sum  <= n_lat_sum;
            r_count    <= n_count;
            r_slot     <= n_slot;
        end
    end

    // Hold the accepted pair
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    // Ring memories: read the oldest entry, write the new pair
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_wait_ring[r_slot] <= r_item.queue_wait_sample;
            r_lat_ring[r_slot]  <= r_item.inference_sample;
        end
        r_rd_wait <= r_wait_ring[r_slot];
        r_rd_lat  <= r_lat_ring[r_slot];
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(WINDOW_DEPTH))
        else $error("fill count above window depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == FS_SUB))
        else $error("accepted item did not start update");

    a_push_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FS_PUSH && !i_job_full) |=> (r_state == FS_IDLE && r_count != '0))
        else $error("job handoff did not return to idle with a nonzero count");
`endif

endmodule

FILE: rtl/pswa_queue.sv
module pswa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  pswa_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_empty,
    output pswa_pkg::t_job o_job
);
    import pswa_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_cnt    = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the job
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/pswa_back.sv
module pswa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    input  pswa_pkg::t_job i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output pswa_pkg::t_out o_result
);
    import pswa_pkg::*;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_DIV  = 3'b010,
        BS_HOLD = 3'b100
    } t_back_state;

    t_back_state r_state, n_state;
    logic [SUM_W-1:0]   r_quo_w, n_quo_w;
    logic [SUM_W-1:0]   r_quo_l, n_quo_l;
    logic [COUNT_W-1:0] r_rem_w, n_rem_w;
    logic [COUNT_W-1:0] r_rem_l, n_rem_l;
    logic [COUNT_W-1:0] r_div, n_div;
    logic [STEP_W-1:0]  r_step, n_step;
    t_out               r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [COUNT_W:0]   shift_w, shift_l;
    logic               ge_w, ge_l;
    logic               out_free;

    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;
    assign o_job_pop = (r_state == BS_IDLE) && !i_job_empty;
    assign out_free  = !r_out_valid || i_pop;

    // Restoring division step, one quotient bit per channel per cycle
    assign shift_w = {r_rem_w, r_quo_w[SUM_W-1]};
    assign shift_l = {r_rem_l, r_quo_l[SUM_W-1]};
    assign ge_w    = (shift_w >= {1'b0, r_div});
    assign ge_l    = (shift_l >= {1'b0, r_div});

    always_comb begin
        n_state     = r_state;
        n_quo_w     = r_quo_w;
        n_quo_l     = r_quo_l;
        n_rem_w     = r_rem_w;
        n_rem_l     = r_rem_l;
        n_div       = r_div;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_job_empty) begin
                    n_quo_w = i_job.wait_sum;
                    n_quo_l = i_job.latency_sum;
                    n_rem_w = '0;
                    n_rem_l = '0;
                    n_div   = i_job.count;
                    n_step  = STEP_W'(SUM_W - 1);
                    n_state = BS_DIV;
                end
            end
            BS_DIV: begin
                n_rem_w = ge_w ? COUNT_W'(shift_w - {1'b0, r_div}) : COUNT_W'(shift_w);
                n_rem_l = ge_l ? COUNT_W'(shift_l - {1'b0, r_div}) : COUNT_W'(shift_l);
                n_quo_w = {r_quo_w[SUM_W-2:0], ge_w};
                n_quo_l = {r_quo_l[SUM_W-2:0], ge_l};
                n_step  = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = BS_HOLD;
                end
            end
            BS_HOLD: begin
                if (out_free) begin
                    n_out.avg_queue_wait = SAMPLE_W'(r_quo_w);
                    n_out.avg_inference  = SAMPLE_W'(r_quo_l);
                    n_out.samples_held   = SAMPLES_W'(r_div);
                    n_out_valid          = 1'b1;
                    n_state              = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo_w <= n_quo_w;
        r_quo_l <= n_quo_l;
        r_rem_w <= n_rem_w;
        r_rem_l <= n_rem_l;
        r_div   <= n_div;
        r_step  <= n_step;
        r_out   <= n_out;
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (i_job.count != '0))
        else $error("division job with zero count");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> (r_out_valid && $stable(r_out)))
        else $error("waiting result changed or vanished");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_DIV && r_step == '0) |=> (r_state == BS_HOLD))
        else $error("division did not finish after last step");
`endif

endmodule

FILE: rtl/paired_sliding_window_average_unit.sv
// Sliding-window average of paired latency samples.
// Input channel: present a sample pair on i_item with push high; the pair is
// taken at a rising edge where push is high and full is low. full stays high
// after each accepted pair until its sums are updated and queued.
// Result channel: while empty is low, o_result holds the oldest result (mean
// queue wait, mean inference latency, pairs in the window); it is taken at a
// rising edge where pop is high and empty is low. Each pair gives exactly one
// result, in order.
// Bit-serial dividers in the back end (one quotient bit per cycle for both
// channels) take a new job only once they are done with the last one.
// A two-entry job queue sits between the sum update and the dividers, and a
// one-entry output register follows them, so the input keeps accepting while
// results wait. When the receiver stalls, the dividers hold their finished
// result, the queue fills, and full then stays high until pop frees space.
// Reset (i_rst_n low at a clock edge) empties the window, sums, queue and
// output; no clearing pass is needed.
module paired_sliding_window_average_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  pswa_pkg::t_in  i_item,
    output logic           empty,
    input  logic           pop,
    output pswa_pkg::t_out o_result
);
    import pswa_pkg::*;

    t_job fq_job;
    t_job qb_job;
    logic fq_push;
    logic fq_full;
    logic qb_pop;
    logic qb_empty;

    // Accept pairs and update the window sums
    pswa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .o_job_push (fq_push),
        .i_job_full (fq_full),
        .o_job      (fq_job)
    );

    // Decouple the sum update from the dividers
    pswa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .o_full  (fq_full),
        .i_job   (fq_job),
        .i_pop   (qb_pop),
        .o_empty (qb_empty),
        .o_job   (qb_job)
    );

    // Divide sums by the count and present results
    pswa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (qb_empty),
        .o_job_pop   (qb_pop),
        .i_job       (qb_job),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

FILE: tb/tb_paired_sliding_window_average_unit.sv
module tb_paired_sliding_window_average_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pswa_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AT_PAIR = 300;
    localparam int PHASE_PAIRS  = 600;
    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_LIMIT = 10;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // Flavors of random sample values
    typedef enum int {
        MIX_ANY,
        MIX_SMALL,
        MIX_HIGH,
        MIX_ALL_ONES,
        MIX_ONE_BIT,
        MIX_COUNT
    } t_mix;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   push = 1'b0;
    logic   pop = 1'b0;
    t_in    i_item = '0;
    logic   full;
    logic   empty;
    t_out   o_result;

    // Pairs waiting to be offered, and averages waiting to come back
    t_in    pending_pairs[$];
    t_out   expected_averages[$];

    // Window mirror
    logic [SAMPLE_W-1:0] wait_hist [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] latency_hist [WINDOW_DEPTH];
    logic [SUM_W-1:0]    wait_total = '0;
    logic [SUM_W-1:0]    latency_total = '0;
    int                  held_count = 0;
    int                  next_slot = 0;

    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     accepted_pairs = 0;
    int     hold_left = 0;
    logic   hold_used = 1'b0;
    int     mismatch_count = 0;
    int     cycle_count = 0;

    paired_sliding_window_average_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Advance the window with one pair and return the averages it yields
    function automatic t_out predict_average(t_in pair);
        t_out avg;
        if (held_count >= WINDOW_DEPTH) begin
            wait_total    = wait_total - SUM_W'(wait_hist[next_slot]);
            latency_total = latency_total - SUM_W'(latency_hist[next_slot]);
        end else begin
            held_count = held_count + 1;
        end
        wait_hist[next_slot]    = pair.queue_wait_sample;
        latency_hist[next_slot] = pair.inference_sample;
        wait_total    = wait_total + SUM_W'(pair.queue_wait_sample);
        latency_total = latency_total + SUM_W'(pair.inference_sample);
        next_slot = (next_slot == WINDOW_DEPTH - 1) ? 0 : next_slot + 1;
        avg.avg_queue_wait = SAMPLE_W'(wait_total / SUM_W'(held_count));
        avg.avg_inference  = SAMPLE_W'(latency_total / SUM_W'(held_count));
        avg.samples_held   = SAMPLES_W'(held_count);
        return avg;
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(t_mix mix);
        case (mix)
            MIX_SMALL:    return SAMPLE_W'($urandom_range(0, 1000));
            MIX_HIGH:     return SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 255));
            MIX_ALL_ONES: return SAMPLE_MAX;
            MIX_ONE_BIT:  return SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1);
            default:      return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic add_pair(logic [SAMPLE_W-1:0] qw, logic [SAMPLE_W-1:0] inf);
        t_in pair;
        pair.queue_wait_sample = qw;
        pair.inference_sample  = inf;
        pending_pairs.insert(pending_pairs.size(), pair);
    endtask

    // Queue random segments; each segment keeps one flavor per channel
    task automatic add_random_pairs(int count);
        int   added;
        int   seg_len;
        t_mix wait_mix;
        t_mix lat_mix;
        added = 0;
        while (added < count) begin
            wait_mix = t_mix'($urandom_range(0, MIX_COUNT - 1));
            lat_mix  = t_mix'($urandom_range(0, MIX_COUNT - 1));
            if (wait_mix == MIX_ALL_ONES || lat_mix == MIX_ALL_ONES) begin
                seg_len = $urandom_range(WINDOW_DEPTH, WINDOW_DEPTH + 40);
            end else begin
                seg_len = $urandom_range(1, 90);
            end
            for (int k = 0; k < seg_len && added < count; k++) begin
                add_pair(draw_sample(wait_mix), draw_sample(lat_mix));
                added++;
            end
        end
    endtask

    // Hold until nothing is pending or outstanding
    task automatic drain_all();
        while (pending_pairs.size() != 0 || push || expected_averages.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_result(t_out got);
        t_out want;
        if (expected_averages.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("unexpected result: wait=%0d inf=%0d held=%0d",
                         got.avg_queue_wait, got.avg_inference, got.samples_held);
            end
            return;
        end
        want = expected_averages.pop_front();
        if (got.avg_queue_wait != want.avg_queue_wait
                || got.avg_inference != want.avg_inference
                || got.samples_held != want.samples_held) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("expected wait=%0d inf=%0d held=%0d, got wait=%0d inf=%0d held=%0d",
                         want.avg_queue_wait, want.avg_inference, want.samples_held,
                         got.avg_queue_wait, got.avg_inference, got.samples_held);
            end
        end
    endtask

    // Driver: offer pending pairs, hold while full, predict on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_averages.insert(expected_averages.size(), predict_average(i_item));
                accepted_pairs <= accepted_pairs + 1;
            end
            if (!(push && full)) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_item <= pending_pairs.pop_front();
                    push   <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off: block pops for a long stretch once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_used && accepted_pairs >= HOLD_AT_PAIR) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each popped result with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_result(o_result);
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_paired_sliding_window_average_unit NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Phase 1: sender idles a little, receiver a lot
        send_idle_pct = 19;
        recv_idle_pct = 57;
        add_pair('0, '0);
        add_pair(SAMPLE_MAX, SAMPLE_MAX);
        add_pair(SAMPLE_MAX, '0);
        add_pair('0, SAMPLE_MAX);
        add_pair(32'hAAAA_AAAA, 32'h5555_5555);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA);
        add_pair(32'h8000_0000, 32'h7FFF_FFFF);
        add_pair(32'h7FFF_FFFF, 32'h8000_0000);
        add_pair(32'd1, 32'd2);
        add_pair(32'd3, 32'd7);
        add_pair(32'h0000_FFFF, 32'hFFFF_0000);
        add_pair(32'hFFFF_0000, 32'h0000_FFFF);
        add_pair(32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_pair(32'hF0F0_F0F0, 32'h0F0F_0F0F);
        add_pair(SAMPLE_MAX, SAMPLE_MAX);
        add_pair('0, '0);
        add_random_pairs(PHASE_PAIRS);
        drain_all();

        // Phase 2: roles swapped
        send_idle_pct = 57;
        recv_idle_pct = 19;
        add_random_pairs(PHASE_PAIRS);
        drain_all();

        // Phase 3: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_pairs(PHASE_PAIRS);
        drain_all();

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && expected_averages.size() == 0) begin
            $display("tb_paired_sliding_window_average_unit OK");
        end else begin
            $display("tb_paired_sliding_window_average_unit NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pswa_pkg.sv
rtl/pswa_front.sv
rtl/pswa_queue.sv
rtl/pswa_back.sv
rtl/paired_sliding_window_average_unit.sv
tb/tb_paired_sliding_window_average_unit.sv
